// File: rtl/go_back_n_aimd_sender_assert.svh
// assertion macros used by the go-back-n sender core
// no dependencies; taken in by `include where assertions are written
`ifndef GO_BACK_N_AIMD_SENDER_ASSERT_SVH
`define GO_BACK_N_AIMD_SENDER_ASSERT_SVH

// same-cycle implication under asynchronous active-low reset
`define GBN_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under asynchronous active-low reset
`define GBN_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/gbnaimd_pkg.sv
// shared types and codes of the go-back-n aimd sender
// no dependencies; used by the register file, core and top level
package gbnaimd_pkg;

    // widths that do not vary with the module parameters
    localparam int CNT_W            = 25;  // effective block count, up to 2^BLOCK_INDEX_BITS
    localparam int LEN_W            = 17;  // last block length, up to 65536
    localparam int ADDR_W           = 5;   // seven word registers
    localparam int SHRINK_FRAC_BITS = 8;   // shrink factor is q0.8

    // command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_ACK   = 2'd2;

    // ack kinds
    localparam logic [1:0] ACK_POS = 2'd0;
    localparam logic [1:0] ACK_NEG = 2'd1;

    // result kinds
    localparam logic [2:0] RK_SENT    = 3'd0;
    localparam logic [2:0] RK_NO_SEND = 3'd1;
    localparam logic [2:0] RK_ACK     = 3'd2;
    localparam logic [2:0] RK_IGNORED = 3'd3;
    localparam logic [2:0] RK_STARTED = 3'd4;

    // register indexes (byte address is four times the index)
    localparam logic [2:0] REG_FILE_SIZE      = 3'd0;
    localparam logic [2:0] REG_BLOCK_COUNT    = 3'd1;
    localparam logic [2:0] REG_INITIAL_WINDOW = 3'd2;
    localparam logic [2:0] REG_WINDOW_STEP_UP = 3'd3;
    localparam logic [2:0] REG_SHRINK_FACTOR  = 3'd4;
    localparam logic [2:0] REG_MIN_WINDOW     = 3'd5;
    localparam logic [2:0] REG_START_OFFSET   = 3'd6;

    // register reset values
    localparam logic [26:0] RST_FILE_SIZE      = 27'd1;
    localparam logic [16:0] RST_BLOCK_COUNT    = 17'd1;
    localparam logic [15:0] RST_INITIAL_WINDOW = 16'd256;
    localparam logic [15:0] RST_WINDOW_STEP_UP = 16'd256;
    localparam logic [7:0]  RST_SHRINK_FACTOR  = 8'd128;
    localparam logic [15:0] RST_MIN_WINDOW     = 16'd256;
    localparam logic [31:0] RST_START_OFFSET   = 32'd0;

    // settings handed from the register file to the core
    typedef struct packed {
        logic [CNT_W-1:0] count;          // block count clamped to 1..2^index bits
        logic [LEN_W-1:0] last_len;       // length of the last block, clamped
        logic [15:0]      initial_window;
        logic [15:0]      window_step_up;
        logic [7:0]       shrink_factor;
        logic [15:0]      min_window;
        logic [31:0]      start_offset;
    } gbnaimd_cfg_t;

endpackage

// File: rtl/gbnaimd_if.sv
// valid/ready channels for the request and result items of the sender
// depends on gbnaimd_pkg for nothing but keeps the field widths of the items
interface gbnaimd_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [1:0]  ack_kind;
    logic [16:0] ack_number;

    modport source (output valid, command, ack_kind, ack_number, input ready);
    modport sink (input valid, command, ack_kind, ack_number, output ready);
endinterface

interface gbnaimd_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_kind;
    logic [15:0] block_index;
    logic [32:0] byte_offset;
    logic [10:0] block_length;
    logic [31:0] iteration_number;
    logic        awaiting_ack;
    logic        transfer_done;
    logic [15:0] window_now;

    modport source (output valid, result_kind, block_index, byte_offset, block_length,
                    iteration_number, awaiting_ack, transfer_done, window_now,
                    input ready);
    modport sink (input valid, result_kind, block_index, byte_offset, block_length,
                  iteration_number, awaiting_ack, transfer_done, window_now,
                  output ready);
endinterface

// File: rtl/go_back_n_aimd_sender.sv
// top level of the go-back-n sender with aimd window sizing
// depends on gbnaimd_pkg, gbnaimd_if.sv, gbnaimd_regs and gbnaimd_core
//
//  channel  | kind            | carries
//  ---------+-----------------+---------------------------------------------------
//  item     | valid/ready in  | command, ack_kind, ack_number
//  result   | valid/ready out | result_kind, block_index, byte_offset, block_length,
//           |                 | iteration_number, awaiting_ack, transfer_done, window_now
//  apb      | register port   | seven settings at byte address 4 * index
//
// one request per cycle while results are taken; each request waits in the request register
// and moves into the result register, the sender state updating at the same edge
// the state update, window multiply and offset multiply sit in the single stage between the two
// a stalled result holds the stage; the request register keeps taking requests
// until it is full as well
// rst_n clears the transfer state and loads the register defaults; no clearing pass
module go_back_n_aimd_sender #(
    parameter int BLOCK_BYTES      = 1024,
    parameter int BLOCK_INDEX_BITS = 16,
    parameter int WINDOW_FRAC_BITS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gbnaimd_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    gbnaimd_item_if.sink                   item,
    gbnaimd_result_if.source               result
);
    import gbnaimd_pkg::*;

    gbnaimd_cfg_t cfg;

    // the register port never waits
    assign pready = 1'b1;

    // settings
    gbnaimd_regs #(
        .BLOCK_BYTES      (BLOCK_BYTES),
        .BLOCK_INDEX_BITS (BLOCK_INDEX_BITS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sender state and result path
    gbnaimd_core #(
        .BLOCK_BYTES      (BLOCK_BYTES),
        .BLOCK_INDEX_BITS (BLOCK_INDEX_BITS),
        .WINDOW_FRAC_BITS (WINDOW_FRAC_BITS)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .result (result)
    );

endmodule

// File: rtl/gbnaimd_regs.sv
// apb register file of the sender, with the derived block count and last length
// depends on gbnaimd_pkg
module gbnaimd_regs #(
    parameter int BLOCK_BYTES      = 1024,
    parameter int BLOCK_INDEX_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gbnaimd_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    input  logic                             pready,
    output gbnaimd_pkg::gbnaimd_cfg_t        cfg
);
    import gbnaimd_pkg::*;

    localparam int PW = CNT_W + 19;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(1) << BLOCK_INDEX_BITS;

    logic [26:0]      file_size_reg;
    logic [16:0]      block_count_reg;
    logic [15:0]      initial_window_reg;
    logic [15:0]      window_step_up_reg;
    logic [7:0]       shrink_factor_reg;
    logic [15:0]      min_window_reg;
    logic [31:0]      start_offset_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [LEN_W-1:0] last_len_reg;
    logic [LEN_W-1:0] last_len_next;
    logic [CNT_W-1:0] bc_ext;
    logic [PW-1:0]    span;
    logic signed [PW:0] rem;
    logic             wr_en;
    logic [2:0]       reg_idx;

    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_size_reg      <= RST_FILE_SIZE;
            block_count_reg    <= RST_BLOCK_COUNT;
            initial_window_reg <= RST_INITIAL_WINDOW;
            window_step_up_reg <= RST_WINDOW_STEP_UP;
            shrink_factor_reg  <= RST_SHRINK_FACTOR;
            min_window_reg     <= RST_MIN_WINDOW;
            start_offset_reg   <= RST_START_OFFSET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_FILE_SIZE:      file_size_reg      <= pwdata[26:0];
                REG_BLOCK_COUNT:    block_count_reg    <= pwdata[16:0];
                REG_INITIAL_WINDOW: initial_window_reg <= pwdata[15:0];
                REG_WINDOW_STEP_UP: window_step_up_reg <= pwdata[15:0];
                REG_SHRINK_FACTOR:  shrink_factor_reg  <= pwdata[7:0];
                REG_MIN_WINDOW:     min_window_reg     <= pwdata[15:0];
                REG_START_OFFSET:   start_offset_reg   <= pwdata;
                default:            ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (reg_idx)
            REG_FILE_SIZE:      prdata = 32'(file_size_reg);
            REG_BLOCK_COUNT:    prdata = 32'(block_count_reg);
            REG_INITIAL_WINDOW: prdata = 32'(initial_window_reg);
            REG_WINDOW_STEP_UP: prdata = 32'(window_step_up_reg);
            REG_SHRINK_FACTOR:  prdata = 32'(shrink_factor_reg);
            REG_MIN_WINDOW:     prdata = 32'(min_window_reg);
            REG_START_OFFSET:   prdata = start_offset_reg;
            default:            prdata = '0;
        endcase
    end

    // clamp the block count and size the last block
    always_comb
    begin
        bc_ext = CNT_W'(block_count_reg);
        if (block_count_reg == '0)
            count_next = CNT_W'(1);
        else if (bc_ext > CNT_MAX)
            count_next = CNT_MAX;
        else
            count_next = bc_ext;

        span = PW'(count_next - CNT_W'(1)) * PW'(BLOCK_BYTES);
        rem  = $signed({1'b0, PW'(file_size_reg)}) - $signed({1'b0, span});
        if (rem < 0)
            last_len_next = '0;
        else if (rem > (PW+1)'(BLOCK_BYTES))
            last_len_next = LEN_W'(BLOCK_BYTES);
        else
            last_len_next = LEN_W'(rem);
    end

    // derived values are registered, so they follow a register write in the next cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= CNT_W'(1);
            last_len_reg <= LEN_W'(1);
        end
        else
        begin
            count_reg    <= count_next;
            last_len_reg <= last_len_next;
        end
    end

    assign cfg.count          = count_reg;
    assign cfg.last_len       = last_len_reg;
    assign cfg.initial_window = initial_window_reg;
    assign cfg.window_step_up = window_step_up_reg;
    assign cfg.shrink_factor  = shrink_factor_reg;
    assign cfg.min_window     = min_window_reg;
    assign cfg.start_offset   = start_offset_reg;

endmodule

// File: rtl/gbnaimd_core.sv
// request register, sender state update and result register of the sender
// depends on gbnaimd_pkg, gbnaimd_if.sv and go_back_n_aimd_sender_assert.svh
`include "go_back_n_aimd_sender_assert.svh"

module gbnaimd_core #(
    parameter int BLOCK_BYTES      = 1024,
    parameter int BLOCK_INDEX_BITS = 16,
    parameter int WINDOW_FRAC_BITS = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  gbnaimd_pkg::gbnaimd_cfg_t cfg,
    gbnaimd_item_if.sink              item,
    gbnaimd_result_if.source          result
);
    import gbnaimd_pkg::*;

    localparam int IW = BLOCK_INDEX_BITS;
    localparam int SW = (IW + 3 > 19) ? IW + 3 : 19;
    localparam int OW = IW + 17;

    // request register
    logic        in_vld_reg;
    logic [1:0]  cmd_reg;
    logic [1:0]  kind_reg;
    logic [16:0] num_reg;
    logic        adv;

    // sender state
    logic [IW-1:0]      next_block_reg, next_block_next;
    logic signed [17:0] last_acked_reg, last_acked_next;
    logic [15:0]        window_reg, window_next;
    logic               rep_nak_reg, rep_nak_next;
    logic               wait_reg, wait_next;
    logic [31:0]        iter_reg, iter_next;
    logic               running_reg, running_next;
    logic               done_reg, done_next;

    // result register
    logic        out_vld_reg;
    logic [2:0]  rk_reg, rk_next;
    logic [15:0] idx_reg, idx_next;
    logic [32:0] off_reg, off_next;
    logic [10:0] len_reg, len_next;
    logic [31:0] tag_reg, tag_next;

    // working values
    logic signed [SW-1:0] cnt_s, cnt1_s, la_s, nb_s, nb1_s, wb_s, d0, d1;
    logic signed [SW-1:0] ack_s, this_ack_s, tgt_s, tick_nb_s, nb_new_s, la_new_s;
    logic                 fit0, fit1, send_ok, step_on, fit_after, sent;
    logic [OW-1:0]        prod_off;
    logic [23:0]          prod_w;
    logic [15:0]          w_shr;
    logic [16:0]          w_sum;

    // a request moves on when the result register is free or being emptied
    assign adv        = in_vld_reg && (!out_vld_reg || result.ready);
    assign item.ready = !in_vld_reg || adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (item.ready)
            in_vld_reg <= item.valid;
    end

    always_ff @(posedge clk)
    begin
        if (item.ready && item.valid)
        begin
            cmd_reg  <= item.command;
            kind_reg <= item.ack_kind;
            num_reg  <= item.ack_number;
        end
    end

    // signed views of indices and counts
    always_comb
    begin
        cnt_s  = SW'($signed({1'b0, cfg.count[IW:0]}));
        cnt1_s = cnt_s - SW'(1);
        la_s   = SW'(last_acked_reg);
        nb_s   = SW'($signed({1'b0, next_block_reg}));
        nb1_s  = nb_s + SW'(1);
        wb_s   = SW'($signed({1'b0, window_reg >> WINDOW_FRAC_BITS}));
        ack_s  = SW'($signed({1'b0, num_reg}));
        d0     = nb_s - la_s;
        d1     = nb1_s - la_s;
        fit0   = (d0 < 0) || (d0 <= wb_s);
        fit1   = (d1 < 0) || (d1 <= wb_s);
    end

    // tick: send decision, offset and the wait check on the advanced index
    always_comb
    begin
        send_ok   = (la_s < cnt1_s) && fit0;
        step_on   = send_ok && (nb_s < cnt1_s);
        tick_nb_s = step_on ? nb1_s : nb_s;
        fit_after = step_on ? fit1 : fit0;
        prod_off  = OW'(next_block_reg) * OW'(BLOCK_BYTES);
    end

    // ack: rewind target and window arithmetic
    always_comb
    begin
        this_ack_s = (num_reg != '0) ? ack_s : la_s;
        if (this_ack_s < 0)
            tgt_s = '0;
        else if (this_ack_s > cnt1_s)
            tgt_s = cnt1_s;
        else
            tgt_s = this_ack_s;
        prod_w = 24'(window_reg) * 24'(cfg.shrink_factor);
        w_shr  = prod_w[SHRINK_FRAC_BITS +: 16];
        w_sum  = {1'b0, window_reg} + {1'b0, cfg.window_step_up};
    end

    // next state and result
    always_comb
    begin
        next_block_next = next_block_reg;
        last_acked_next = last_acked_reg;
        window_next     = window_reg;
        rep_nak_next    = rep_nak_reg;
        wait_next       = wait_reg;
        iter_next       = iter_reg;
        running_next    = running_reg;
        done_next       = done_reg;
        rk_next         = RK_IGNORED;
        idx_next        = '0;
        off_next        = '0;
        len_next        = '0;
        sent            = 1'b0;
        nb_new_s        = nb_s;
        la_new_s        = la_s;

        case (cmd_reg)
            CMD_START:
            begin
                next_block_next = '0;
                last_acked_next = -18'sd1;
                window_next     = cfg.initial_window;
                rep_nak_next    = 1'b0;
                wait_next       = 1'b0;
                iter_next       = '0;
                running_next    = 1'b1;
                done_next       = 1'b0;
                rk_next         = RK_STARTED;
            end
            CMD_TICK:
            begin
                if (running_reg && !wait_reg)
                begin
                    if (send_ok)
                    begin
                        sent     = 1'b1;
                        idx_next = 16'(next_block_reg);
                        off_next = 33'(cfg.start_offset) + 33'(prod_off);
                        len_next = (nb_s == cnt1_s) ? cfg.last_len[10:0]
                                                    : 11'(BLOCK_BYTES);
                    end
                    next_block_next = IW'(tick_nb_s);
                    if (!fit_after || ((tick_nb_s == cnt1_s) && (la_s < cnt_s)))
                        wait_next = 1'b1;
                    else
                        iter_next = iter_reg + 32'd1;
                    rk_next = sent ? RK_SENT : RK_NO_SEND;
                end
            end
            CMD_ACK:
            begin
                if (running_reg && wait_reg)
                begin
                    if (kind_reg != ACK_POS)
                    begin
                        // a negative ack right after another is swallowed
                        if (!rep_nak_reg || (kind_reg != ACK_NEG))
                        begin
                            nb_new_s        = tgt_s;
                            la_new_s        = this_ack_s;
                            next_block_next = IW'(tgt_s);
                            last_acked_next = 18'(this_ack_s);
                            window_next     = (w_shr < cfg.min_window) ? cfg.min_window
                                                                       : w_shr;
                            rep_nak_next    = (kind_reg == ACK_NEG);
                        end
                    end
                    else
                    begin
                        if (la_s <= this_ack_s)
                        begin
                            window_next     = w_sum[16] ? 16'hFFFF : w_sum[15:0];
                            last_acked_next = 18'(this_ack_s);
                            la_new_s        = this_ack_s;
                        end
                        rep_nak_next = 1'b0;
                    end
                    wait_next = 1'b0;
                    iter_next = iter_reg + 32'd1;
                    if (!((nb_new_s < cnt1_s) || (la_new_s < cnt_s)))
                    begin
                        running_next = 1'b0;
                        done_next    = 1'b1;
                    end
                    rk_next = RK_ACK;
                end
            end
            default: ;
        endcase

        tag_next = sent ? iter_reg : iter_next;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_block_reg <= '0;
            last_acked_reg <= -18'sd1;
            window_reg     <= '0;
            rep_nak_reg    <= 1'b0;
            wait_reg       <= 1'b0;
            iter_reg       <= '0;
            running_reg    <= 1'b0;
            done_reg       <= 1'b0;
        end
        else if (adv)
        begin
            next_block_reg <= next_block_next;
            last_acked_reg <= last_acked_next;
            window_reg     <= window_next;
            rep_nak_reg    <= rep_nak_next;
            wait_reg       <= wait_next;
            iter_reg       <= iter_next;
            running_reg    <= running_next;
            done_reg       <= done_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= 1'b1;
        else if (result.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rk_reg  <= rk_next;
            idx_reg <= idx_next;
            off_reg <= off_next;
            len_reg <= len_next;
            tag_reg <= tag_next;
        end
    end

    assign result.valid            = out_vld_reg;
    assign result.result_kind      = rk_reg;
    assign result.block_index      = idx_reg;
    assign result.byte_offset      = off_reg;
    assign result.block_length     = len_reg;
    assign result.iteration_number = tag_reg;
    assign result.awaiting_ack     = wait_reg;
    assign result.transfer_done    = done_reg;
    assign result.window_now       = window_reg;

    // checks
    `GBN_ASSERT_NOW(a_done_not_running, clk, rst_n, done_reg, !running_reg,
        "transfer marked done while still running")
    `GBN_ASSERT_NOW(a_wait_needs_run, clk, rst_n, wait_reg, running_reg,
        "waiting for an ack outside a running transfer")
    `GBN_ASSERT_NEXT(a_adv_gives_result, clk, rst_n, adv, out_vld_reg,
        "request advanced without a result")
    `GBN_ASSERT_NEXT(a_start_clears, clk, rst_n, adv && (cmd_reg == CMD_START),
        running_reg && !wait_reg && (iter_reg == '0),
        "start did not reset the transfer state")

endmodule
